// ===== src/mte_pkg.sv =====
// shared types, constants and helper functions for the midi track event encoder
// no dependencies; imported by every module of the block
package mte_pkg;

  localparam int STORE_DEPTH       = 256;
  localparam int ADDR_W            = $clog2(STORE_DEPTH);
  localparam int CNT_W             = ADDR_W + 1;
  localparam int TICKS_PER_QUARTER = 480;
  localparam int TICK_W            = 28;
  // product width covers a 32 bit beat times the tick scale plus the rounding shift
  localparam int PROD_W            = 48;
  localparam int ROUND_BIT         = 16;
  localparam int LEN_W             = 16;
  localparam int EOT_BYTES         = 4;

  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_CTRL     = 8'hB0;
  localparam logic [7:0] STATUS_PROGRAM  = 8'hC0;
  localparam logic [7:0] META_PREFIX     = 8'hFF;
  localparam logic [7:0] META_EOT        = 8'h2F;

  typedef enum logic [1:0] {
    MODE_NOTE  = 2'd0,
    MODE_CC    = 2'd1,
    MODE_PC    = 2'd2,
    MODE_DRAIN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_OFF = 2'd0,
    KIND_ON  = 2'd1,
    KIND_CC  = 2'd2,
    KIND_PC  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    kind_t             kind;
    logic [6:0]        d1;
    logic [6:0]        d2;
  } entry_t;

  typedef struct packed {
    logic              live;
    logic [ADDR_W-1:0] idx;
    entry_t            entry;
  } scan_probe_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] idx;
    entry_t            entry;
  } scan_best_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_WR_FIRST,
    S_WR_SECOND,
    S_SCAN,
    S_SCAN_DONE,
    S_EMIT,
    S_EOT
  } state_t;

  function automatic logic [6:0] ctrl_number(input logic [2:0] sel);
    logic [6:0] num;
    case (sel)
      3'd1:    num = 7'd10;
      3'd2:    num = 7'd73;
      3'd3:    num = 7'd64;
      3'd4:    num = 7'd1;
      3'd5:    num = 7'd91;
      default: num = 7'd7;
    endcase
    return num;
  endfunction

  function automatic logic [6:0] clamp7(input logic signed [15:0] v,
                                        input logic signed [15:0] lo);
    logic [6:0] r;
    if (v < lo) begin
      r = lo[6:0];
    end else if (v > 16'sd127) begin
      r = 7'd127;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

endpackage

// ===== src/midi_track_event_encoder_unit.sv =====
// add items: S_TICK, S_WR_FIRST and, for a note, S_WR_SECOND from start back to idle;
// a rejected add gives its single dropped result in the cycle after start
// drain: a scan of slots 0 to next_slot - 1 over the store read port, the S_SCAN_DONE decision,
// then one byte per cycle (3 to 7 bytes)
// results come one per cycle from an output register and cannot be stalled
// synchronous active high reset empties the store and zeroes the channel
module midi_track_event_encoder_unit
  import mte_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic signed [31:0] beat,
  input  logic signed [31:0] duration,
  input  logic signed [15:0] note_number,
  input  logic signed [15:0] level,
  input  logic [2:0]         controller_kind,
  input  logic               cfg_write_en,
  input  logic [3:0]         midi_channel,
  output logic               strobe,
  output logic [7:0]         out_byte,
  output logic               last_byte,
  output logic               end_of_track,
  output logic [LEN_W-1:0]   body_length,
  output logic               dropped
);

  state_t             state;
  state_t             state_next;
  logic [3:0]         channel;
  logic [STORE_DEPTH-1:0] slot_valid;
  logic [CNT_W-1:0]   next_slot;
  logic [CNT_W-1:0]   rd_addr;
  logic               rd_pending;
  logic [ADDR_W-1:0]  rd_idx;
  logic [TICK_W-1:0]  previous_tick;
  logic [LEN_W-1:0]   byte_count;
  mode_t              add_mode;
  logic [6:0]         add_d1;
  logic [6:0]         add_d2;
  entry_t             ev;
  logic [TICK_W-1:0]  delta;
  logic [2:0]         n_groups;
  logic [2:0]         n_bytes;
  logic [2:0]         byte_idx;

  mode_t              mode_in;
  logic               accept;
  logic [CNT_W-1:0]   free_slots;
  logic [CNT_W-1:0]   need;
  logic               no_room;
  logic               drop;
  logic               issue;
  logic               emit_last;
  logic               eot_last;

  logic               mem_we;
  entry_t             mem_wdata;
  entry_t             rdata;
  logic [TICK_W-1:0]  on_tick;
  logic [TICK_W-1:0]  off_tick;
  scan_probe_t        probe;
  scan_best_t         best;
  logic               scan_clear;

  logic [TICK_W-1:0]  delta_c;
  logic [2:0]         groups_c;
  logic [2:0]         grp_k;
  logic [2:0]         data_j;
  logic [7:0]         status_c;
  logic [7:0]         emit_byte;

  assign mode_in    = mode_t'(mode);
  assign busy       = (state != S_IDLE);
  assign accept     = start && (state == S_IDLE);
  assign free_slots = CNT_W'(STORE_DEPTH) - next_slot;
  assign need       = (mode_in == MODE_NOTE) ? CNT_W'(2) : CNT_W'(1);
  assign no_room    = free_slots < need;
  assign drop       = accept && (mode_in != MODE_DRAIN) && no_room;
  assign scan_clear = accept && (mode_in == MODE_DRAIN);
  assign issue      = (state == S_SCAN) && (rd_addr != next_slot);
  assign emit_last  = (byte_idx == n_bytes - 3'd1);
  assign eot_last   = (byte_idx == 3'(EOT_BYTES - 1));

  mte_tick u_tick (
    .clk      (clk),
    .load     (accept),
    .beat     (beat),
    .duration (duration),
    .on_tick  (on_tick),
    .off_tick (off_tick)
  );

  mte_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (next_slot[ADDR_W-1:0]),
    .wdata (mem_wdata),
    .raddr (rd_addr[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign probe = '{live: rd_pending && slot_valid[rd_idx], idx: rd_idx, entry: rdata};

  mte_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .clear (scan_clear),
    .probe (probe),
    .best  (best)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode_in == MODE_DRAIN) begin
            state_next = S_SCAN;
          end else if (!no_room) begin
            state_next = S_TICK;
          end
        end
      end
      S_TICK: state_next = S_WR_FIRST;
      S_WR_FIRST: begin
        mem_we     = 1'b1;
        state_next = (add_mode == MODE_NOTE) ? S_WR_SECOND : S_IDLE;
      end
      S_WR_SECOND: begin
        mem_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (rd_addr == next_slot) begin
          state_next = S_SCAN_DONE;
        end
      end
      S_SCAN_DONE: state_next = best.found ? S_EMIT : S_EOT;
      S_EMIT: begin
        if (emit_last) begin
          state_next = S_IDLE;
        end
      end
      S_EOT: begin
        if (eot_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // entry written to the store
  always_comb begin
    mem_wdata.tick = on_tick;
    mem_wdata.d1   = add_d1;
    mem_wdata.d2   = add_d2;
    case (add_mode)
      MODE_NOTE: mem_wdata.kind = KIND_ON;
      MODE_CC:   mem_wdata.kind = KIND_CC;
      default:   mem_wdata.kind = KIND_PC;
    endcase
    if (state == S_WR_SECOND) begin
      mem_wdata.tick = off_tick;
      mem_wdata.kind = KIND_OFF;
      mem_wdata.d2   = 7'd0;
    end
  end

  // delta and variable-length group count for the winning entry
  always_comb begin
    delta_c = (best.entry.tick >= previous_tick) ? best.entry.tick - previous_tick : '0;
    if (delta_c[27:21] != '0) begin
      groups_c = 3'd4;
    end else if (delta_c[20:14] != '0) begin
      groups_c = 3'd3;
    end else if (delta_c[13:7] != '0) begin
      groups_c = 3'd2;
    end else begin
      groups_c = 3'd1;
    end
  end

  // byte selection for the current run position
  always_comb begin
    grp_k  = n_groups - 3'd1 - byte_idx;
    data_j = byte_idx - n_groups;
    case (ev.kind)
      KIND_ON:  status_c = STATUS_NOTE_ON;
      KIND_OFF: status_c = STATUS_NOTE_OFF;
      KIND_CC:  status_c = STATUS_CTRL;
      default:  status_c = STATUS_PROGRAM;
    endcase
    status_c  = status_c | {4'd0, channel};
    emit_byte = 8'h00;
    if (state == S_EOT) begin
      case (byte_idx)
        3'd1:    emit_byte = META_PREFIX;
        3'd2:    emit_byte = META_EOT;
        default: emit_byte = 8'h00;
      endcase
    end else if (byte_idx < n_groups) begin
      // most significant group first, continuation bit on all but the last
      case (grp_k)
        3'd0:    emit_byte = {1'b0, delta[6:0]};
        3'd1:    emit_byte = {1'b1, delta[13:7]};
        3'd2:    emit_byte = {1'b1, delta[20:14]};
        default: emit_byte = {1'b1, delta[27:21]};
      endcase
    end else begin
      case (data_j)
        3'd0:    emit_byte = status_c;
        3'd1:    emit_byte = {1'b0, ev.d1};
        default: emit_byte = (ev.kind == KIND_OFF) ? 8'h00 : {1'b0, ev.d2};
      endcase
    end
  end

  // control state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel       <= '0;
      slot_valid    <= '0;
      next_slot     <= '0;
      previous_tick <= '0;
      byte_count    <= '0;
      rd_pending    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        channel <= midi_channel;
      end
      rd_pending <= issue;
      if (mem_we) begin
        slot_valid[next_slot[ADDR_W-1:0]] <= 1'b1;
        next_slot <= next_slot + CNT_W'(1);
      end
      if (state == S_SCAN_DONE && best.found) begin
        slot_valid[best.idx] <= 1'b0;
        previous_tick        <= best.entry.tick;
        byte_count           <= byte_count +
                                LEN_W'(groups_c + ((best.entry.kind == KIND_PC) ? 3'd2 : 3'd3));
      end
      // empty drain closes the track and starts over
      if (state == S_EOT && eot_last) begin
        slot_valid    <= '0;
        next_slot     <= '0;
        previous_tick <= '0;
        byte_count    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      add_mode <= mode_in;
      rd_addr  <= '0;
      case (mode_in)
        MODE_NOTE: begin
          add_d1 <= clamp7(note_number, 16'sd0);
          add_d2 <= clamp7(level, 16'sd1);
        end
        MODE_CC: begin
          add_d1 <= ctrl_number(controller_kind);
          add_d2 <= clamp7(level, 16'sd0);
        end
        default: begin
          add_d1 <= clamp7(level, 16'sd0);
          add_d2 <= 7'd0;
        end
      endcase
    end
    if (issue) begin
      rd_addr <= rd_addr + CNT_W'(1);
    end
    rd_idx <= rd_addr[ADDR_W-1:0];
    if (state == S_SCAN_DONE) begin
      ev       <= best.entry;
      delta    <= delta_c;
      n_groups <= groups_c;
      n_bytes  <= groups_c + ((best.entry.kind == KIND_PC) ? 3'd2 : 3'd3);
      byte_idx <= '0;
    end else if (state == S_EMIT || state == S_EOT) begin
      byte_idx <= byte_idx + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe       <= 1'b0;
      out_byte     <= '0;
      last_byte    <= 1'b0;
      end_of_track <= 1'b0;
      body_length  <= '0;
      dropped      <= 1'b0;
    end else begin
      strobe       <= drop || (state == S_EMIT) || (state == S_EOT);
      out_byte     <= drop ? 8'h00 : emit_byte;
      last_byte    <= drop || (state == S_EMIT && emit_last) || (state == S_EOT && eot_last);
      end_of_track <= !drop && (state == S_EOT);
      body_length  <= (!drop && state == S_EOT && eot_last) ?
                      byte_count + LEN_W'(EOT_BYTES) : '0;
      dropped      <= drop;
    end
  end

`ifndef SYNTH
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    next_slot <= CNT_W'(STORE_DEPTH))
    else $error("next_slot beyond store depth");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> next_slot < CNT_W'(STORE_DEPTH))
    else $error("store write with no free slot");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> rd_addr <= next_slot)
    else $error("scan address ran past the fill count");

  a_drop_alone: assert property (@(posedge clk) disable iff (rst)
    strobe && dropped |-> last_byte && !end_of_track && out_byte == 8'h00)
    else $error("dropped result carries event data");

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    strobe && end_of_track && last_byte |-> next_slot == '0 && byte_count == '0)
    else $error("store not cleared after end of track");
`endif

endmodule

// ===== src/mte_store.sv =====
// event store: single port write, registered read, one entry per slot
// depends on mte_pkg
module mte_store
  import mte_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mte_tick.sv =====
// beat to tick conversion: clamp, scale by ticks per quarter, round, keep 28 bits
// two register stages; depends on mte_pkg
module mte_tick
  import mte_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic signed [31:0] beat,
  input  logic signed [31:0] duration,
  output logic [TICK_W-1:0]  on_tick,
  output logic [TICK_W-1:0]  off_tick
);

  logic signed [32:0] end_beat;
  logic [31:0]        q_on;
  logic [31:0]        q_off;
  logic [PROD_W-1:0]  prod_on;
  logic [PROD_W-1:0]  prod_off;
  logic [PROD_W-1:0]  rnd_on;
  logic [PROD_W-1:0]  rnd_off;
  logic [TICK_W-1:0]  on_raw;
  logic [TICK_W-1:0]  off_raw;

  assign end_beat = {beat[31], beat} + {duration[31], duration};
  // negative beats count as zero
  assign q_on  = beat[31] ? '0 : {1'b0, beat[30:0]};
  assign q_off = end_beat[32] ? '0 : end_beat[31:0];

  always_ff @(posedge clk) begin
    if (load) begin
      prod_on  <= PROD_W'(q_on) * PROD_W'(TICKS_PER_QUARTER);
      prod_off <= PROD_W'(q_off) * PROD_W'(TICKS_PER_QUARTER);
    end
  end

  assign rnd_on  = prod_on + (PROD_W'(1) << (ROUND_BIT - 1));
  assign rnd_off = prod_off + (PROD_W'(1) << (ROUND_BIT - 1));
  assign on_raw  = rnd_on[ROUND_BIT +: TICK_W];
  assign off_raw = rnd_off[ROUND_BIT +: TICK_W];

  // note-off is pushed past the note-on when it does not land after it
  always_ff @(posedge clk) begin
    on_tick  <= on_raw;
    off_tick <= (off_raw <= on_raw) ? on_raw + TICK_W'(1) : off_raw;
  end

endmodule

// ===== src/mte_scan.sv =====
// earliest-event tracker fed one store entry per cycle during a drain scan
// order: lower tick, then non note-on before note-on, then lower slot; depends on mte_pkg
module mte_scan
  import mte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  scan_probe_t probe,
  output scan_best_t  best
);

  logic              found;
  logic [ADDR_W-1:0] idx;
  entry_t            entry;
  logic              better;

  always_comb begin
    better = 1'b0;
    if (probe.live) begin
      if (!found) begin
        better = 1'b1;
      end else if (probe.entry.tick < entry.tick) begin
        better = 1'b1;
      end else if (probe.entry.tick == entry.tick && probe.entry.kind != KIND_ON &&
                   entry.kind == KIND_ON) begin
        better = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
    end else if (better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      idx   <= probe.idx;
      entry <= probe.entry;
    end
  end

  assign best = '{found: found, idx: idx, entry: entry};

endmodule

// ===== sim/tb_midi_track_event_encoder_unit.sv =====
// self-checking testbench for midi_track_event_encoder_unit: directed and random requests
// against a behavioral model of the track event store and its byte encoder
// depends on mte_pkg (src/mte_pkg.sv) and the top level of the block
module tb_midi_track_event_encoder_unit;
  import mte_pkg::*;

  localparam int RUN_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic signed [31:0] ONE_BEAT = 32'sh0001_0000;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    kind_t             kind;
    logic [6:0]        d1;
    logic [6:0]        d2;
  } stored_event_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             eot;
    logic [LEN_W-1:0] len;
    logic             drop;
  } track_byte_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         mode;
  logic signed [31:0] beat;
  logic signed [31:0] duration;
  logic signed [15:0] note_number;
  logic signed [15:0] level;
  logic [2:0]         controller_kind;
  logic               cfg_write_en;
  logic [3:0]         midi_channel;
  logic               strobe;
  logic [7:0]         out_byte;
  logic               last_byte;
  logic               end_of_track;
  logic [LEN_W-1:0]   body_length;
  logic               dropped;

  // model of the block
  stored_event_t     track_store [STORE_DEPTH];
  bit                slot_live [STORE_DEPTH];
  int                fill_level;
  int                live_events;
  logic [TICK_W-1:0] last_tick;
  logic [LEN_W-1:0]  emitted_bytes;
  logic [3:0]        channel_nibble;

  track_byte_t expected_bytes[$];
  track_byte_t head_byte;
  int          error_count;
  bit          idle_gaps;
  int          burst_left;

  midi_track_event_encoder_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .beat            (beat),
    .duration        (duration),
    .note_number     (note_number),
    .level           (level),
    .controller_kind (controller_kind),
    .cfg_write_en    (cfg_write_en),
    .midi_channel    (midi_channel),
    .strobe          (strobe),
    .out_byte        (out_byte),
    .last_byte       (last_byte),
    .end_of_track    (end_of_track),
    .body_length     (body_length),
    .dropped         (dropped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("midi_track_event_encoder_unit verification failed");
    $finish;
  end

  function automatic logic [TICK_W-1:0] beat_to_tick(input longint q);
    logic [63:0] t;
    if (q < 0) q = 0;
    t = q * TICKS_PER_QUARTER + 32768;
    t = t >> 16;
    return t[TICK_W-1:0];
  endfunction

  function automatic logic [6:0] clamp_field(input logic signed [15:0] v, input int lo);
    int x;
    x = v;
    if (x < lo) return 7'(lo);
    if (x > 127) return 7'd127;
    return 7'(x);
  endfunction

  function automatic logic [6:0] controller_number(input logic [2:0] sel);
    case (sel)
      3'd1:    return 7'd10;
      3'd2:    return 7'd73;
      3'd3:    return 7'd64;
      3'd4:    return 7'd1;
      3'd5:    return 7'd91;
      default: return 7'd7;
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] data, input bit last, input bit eot,
                                    input logic [LEN_W-1:0] len, input bit drop);
    track_byte_t r;
    r.data = data;
    r.last = last;
    r.eot  = eot;
    r.len  = len;
    r.drop = drop;
    expected_bytes.push_back(r);
  endfunction

  function automatic void store_event(input logic [TICK_W-1:0] tick, input kind_t kind,
                                      input logic [6:0] d1, input logic [6:0] d2);
    track_store[fill_level] = '{tick: tick, kind: kind, d1: d1, d2: d2};
    slot_live[fill_level] = 1'b1;
    fill_level++;
    live_events++;
  endfunction

  function automatic void predict_drain();
    int                best;
    bit                found;
    bit                is_on;
    bit                best_on;
    logic [TICK_W-1:0] best_tick;
    logic [TICK_W-1:0] delta;
    int                groups;
    stored_event_t     ev;
    logic [7:0]        seq[$];
    found = 1'b0;
    best = 0;
    best_on = 1'b0;
    best_tick = '0;
    // note-ons lose ties to everything else, then the lower slot wins
    for (int i = 0; i < fill_level; i++) begin
      if (slot_live[i]) begin
        is_on = (track_store[i].kind == KIND_ON);
        if (!found || track_store[i].tick < best_tick ||
            (track_store[i].tick == best_tick && is_on < best_on)) begin
          found = 1'b1;
          best = i;
          best_tick = track_store[i].tick;
          best_on = is_on;
        end
      end
    end
    if (!found) begin
      emitted_bytes = emitted_bytes + LEN_W'(EOT_BYTES);
      push_byte(8'h00, 1'b0, 1'b1, '0, 1'b0);
      push_byte(META_PREFIX, 1'b0, 1'b1, '0, 1'b0);
      push_byte(META_EOT, 1'b0, 1'b1, '0, 1'b0);
      push_byte(8'h00, 1'b1, 1'b1, emitted_bytes, 1'b0);
      for (int i = 0; i < STORE_DEPTH; i++) slot_live[i] = 1'b0;
      fill_level = 0;
      live_events = 0;
      last_tick = '0;
      emitted_bytes = '0;
    end else begin
      ev = track_store[best];
      // an event earlier than the last one sent goes out with a zero delta
      delta = (ev.tick >= last_tick) ? ev.tick - last_tick : '0;
      last_tick = ev.tick;
      slot_live[best] = 1'b0;
      live_events--;
      groups = 1;
      while (groups < 4 && (delta >> (7 * groups)) != 0) groups++;
      for (int g = groups - 1; g >= 0; g--) seq.push_back({g != 0, 7'(delta >> (7 * g))});
      case (ev.kind)
        KIND_ON: begin
          seq.push_back(STATUS_NOTE_ON | {4'h0, channel_nibble});
          seq.push_back({1'b0, ev.d1});
          seq.push_back({1'b0, ev.d2});
        end
        KIND_OFF: begin
          seq.push_back(STATUS_NOTE_OFF | {4'h0, channel_nibble});
          seq.push_back({1'b0, ev.d1});
          seq.push_back(8'h00);
        end
        KIND_CC: begin
          seq.push_back(STATUS_CTRL | {4'h0, channel_nibble});
          seq.push_back({1'b0, ev.d1});
          seq.push_back({1'b0, ev.d2});
        end
        default: begin
          seq.push_back(STATUS_PROGRAM | {4'h0, channel_nibble});
          seq.push_back({1'b0, ev.d1});
        end
      endcase
      emitted_bytes = emitted_bytes + LEN_W'(seq.size());
      foreach (seq[k]) push_byte(seq[k], k == seq.size() - 1, 1'b0, '0, 1'b0);
    end
  endfunction

  function automatic void predict_request(input mode_t m, input logic signed [31:0] b,
                                          input logic signed [31:0] d,
                                          input logic signed [15:0] nn,
                                          input logic signed [15:0] lv,
                                          input logic [2:0] ck);
    int                need;
    logic [TICK_W-1:0] on_tick;
    logic [TICK_W-1:0] off_tick;
    logic [6:0]        pitch;
    if (m == MODE_DRAIN) begin
      predict_drain();
    end else begin
      need = (m == MODE_NOTE) ? 2 : 1;
      if (STORE_DEPTH - fill_level < need) begin
        push_byte(8'h00, 1'b1, 1'b0, '0, 1'b1);
      end else if (m == MODE_NOTE) begin
        on_tick = beat_to_tick(longint'(b));
        off_tick = beat_to_tick(longint'(b) + longint'(d));
        if (off_tick <= on_tick) off_tick = on_tick + 1'b1;
        pitch = clamp_field(nn, 0);
        store_event(on_tick, KIND_ON, pitch, clamp_field(lv, 1));
        store_event(off_tick, KIND_OFF, pitch, 7'd0);
      end else if (m == MODE_CC) begin
        store_event(beat_to_tick(longint'(b)), KIND_CC, controller_number(ck),
                    clamp_field(lv, 0));
      end else begin
        store_event(beat_to_tick(longint'(b)), KIND_PC, clamp_field(lv, 0), 7'd0);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %0h", out_byte);
        error_count++;
      end else begin
        head_byte = expected_bytes.pop_front();
        if (out_byte !== head_byte.data) begin
          $error("out_byte: expected %0h, actual %0h", head_byte.data, out_byte);
          error_count++;
        end
        if (last_byte !== head_byte.last) begin
          $error("last_byte: expected %0d, actual %0d", head_byte.last, last_byte);
          error_count++;
        end
        if (end_of_track !== head_byte.eot) begin
          $error("end_of_track: expected %0d, actual %0d", head_byte.eot, end_of_track);
          error_count++;
        end
        if (body_length !== head_byte.len) begin
          $error("body_length: expected %0d, actual %0d", head_byte.len, body_length);
          error_count++;
        end
        if (dropped !== head_byte.drop) begin
          $error("dropped: expected %0d, actual %0d", head_byte.drop, dropped);
          error_count++;
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(input mode_t m, input logic signed [31:0] b,
                              input logic signed [31:0] d, input logic signed [15:0] nn,
                              input logic signed [15:0] lv, input logic [2:0] ck);
    if (idle_gaps && burst_left == 0) begin
      start = 1'b0;
      // long gaps now and then so idle time lands deep inside a store scan
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 300)) @(negedge clk);
      else repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (idle_gaps) burst_left--;
    mode = m;
    beat = b;
    duration = d;
    note_number = nn;
    level = lv;
    controller_kind = ck;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_request(m, b, d, nn, lv, ck);
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_q16_16();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2:       return -int'($urandom_range(0, 32'h0002_0000));
      default: return $urandom_range(0, 32'h0008_0000);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_field16();
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom);
      2:       return 16'(int'($urandom_range(0, 6)) - 3);
      3:       return 16'($urandom_range(125, 131));
      default: return 16'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic send_drain();
    send_request(MODE_DRAIN, $urandom, $urandom, 16'($urandom), 16'($urandom), 3'($urandom));
  endtask

  task automatic send_random_add(input mode_t m);
    send_request(m, rand_q16_16(), rand_q16_16(), rand_field16(), rand_field16(),
                 3'($urandom_range(0, 7)));
  endtask

  task automatic drain_until_empty();
    while (live_events > 0) send_drain();
    send_drain();
  endtask

  task automatic set_channel(input logic [3:0] value);
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write_en = 1'b1;
    midi_channel = value;
    channel_nibble = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  task automatic test_basic_events();
    idle_gaps = 1'b1;
    send_drain();
    send_request(MODE_NOTE, 32'sd0, ONE_BEAT, 16'sd60, 16'sd100, 3'd0);
    send_request(MODE_CC, 32'sd0, 32'sd0, 16'sd0, 16'sd200, 3'd3);
    send_request(MODE_PC, 32'sd0, 32'sd0, 16'sd0, -16'sd5, 3'd0);
    // negative start and length: on at zero, off forced one tick later
    send_request(MODE_NOTE, 32'sh8000_0000, 32'sh8000_0000, 16'sd200, 16'sh8000, 3'd0);
    // largest beats give four byte deltas
    send_request(MODE_NOTE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -16'sd1, 16'sh7FFF, 3'd7);
    // exact half tick rounds up
    send_request(MODE_PC, 32'sd1024, 32'sd0, 16'sd0, 16'sd127, 3'd0);
    drain_until_empty();
  endtask

  task automatic test_controller_kinds();
    set_channel(4'd9);
    idle_gaps = 1'b1;
    for (int k = 0; k < 8; k++) begin
      send_request(MODE_CC, 2 * ONE_BEAT, rand_q16_16(), rand_field16(), rand_field16(),
                   3'(k));
    end
    drain_until_empty();
  endtask

  task automatic test_late_event();
    idle_gaps = 1'b0;
    send_request(MODE_NOTE, 4 * ONE_BEAT, ONE_BEAT, 16'sd72, 16'sd64, 3'd0);
    send_drain();
    send_request(MODE_CC, ONE_BEAT, 32'sd0, 16'sd0, 16'sd33, 3'd1);
    drain_until_empty();
  endtask

  task automatic test_random_traffic(input int count, input bit with_gaps);
    int pick;
    idle_gaps = with_gaps;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) send_random_add(MODE_NOTE);
      else if (pick < 50) send_random_add(MODE_CC);
      else if (pick < 60) send_random_add(MODE_PC);
      else if (pick < 95) send_drain();
      else drain_until_empty();
    end
    drain_until_empty();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_NOTE;
    beat = '0;
    duration = '0;
    note_number = '0;
    level = '0;
    controller_kind = '0;
    cfg_write_en = 1'b0;
    midi_channel = '0;
    for (int i = 0; i < STORE_DEPTH; i++) slot_live[i] = 1'b0;
    fill_level = 0;
    live_events = 0;
    last_tick = '0;
    emitted_bytes = '0;
    channel_nibble = '0;
    error_count = 0;
    idle_gaps = 1'b0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_events();
    test_controller_kinds();
    test_late_event();
    set_channel(4'd15);
    test_random_traffic(16, 1'b1);
    set_channel(4'd0);
    test_random_traffic(16, 1'b0);
    set_channel(4'($urandom_range(1, 14)));
    test_random_traffic(16, 1'b1);

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("midi_track_event_encoder_unit verification clean");
    end else begin
      $display("midi_track_event_encoder_unit verification failed");
    end
    $finish;
  end

endmodule
